/* src/cia_pkg.sv */
// shared types and codes for the timer, port and interrupt block
`default_nettype none

package cia_pkg;

   // command codes of one transaction
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;
   localparam logic [1:0] CMD_FLAG  = 2'd3;

   // register map
   localparam logic [3:0] REG_PRA   = 4'h0;
   localparam logic [3:0] REG_PRB   = 4'h1;
   localparam logic [3:0] REG_DDRA  = 4'h2;
   localparam logic [3:0] REG_DDRB  = 4'h3;
   localparam logic [3:0] REG_TALO  = 4'h4;
   localparam logic [3:0] REG_TAHI  = 4'h5;
   localparam logic [3:0] REG_TBLO  = 4'h6;
   localparam logic [3:0] REG_TBHI  = 4'h7;
   localparam logic [3:0] REG_TOD0  = 4'h8;
   localparam logic [3:0] REG_TOD1  = 4'h9;
   localparam logic [3:0] REG_TOD2  = 4'hA;
   localparam logic [3:0] REG_TOD3  = 4'hB;
   localparam logic [3:0] REG_SDR   = 4'hC;
   localparam logic [3:0] REG_ICR   = 4'hD;
   localparam logic [3:0] REG_CRA   = 4'hE;
   localparam logic [3:0] REG_CRB   = 4'hF;

   // control register bits
   localparam int CR_START   = 0;
   localparam int CR_ONESHOT = 3;
   localparam int CR_LOAD    = 4;
   localparam int CR_CHAIN   = 6;

   // interrupt register bits
   localparam int ICR_TA      = 0;
   localparam int ICR_TB      = 1;
   localparam int ICR_FLAG    = 4;
   localparam int ICR_SUMMARY = 7;
   localparam int ICR_SET     = 7;

   localparam logic [15:0] TIMER_RESET = 16'hFFFF;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] reg_addr;
      logic [7:0] write_data;
      logic [7:0] port_a_pins;
      logic [7:0] port_b_pins;
      logic       flag_level;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
      logic [7:0] port_a_out;
      logic [7:0] port_b_out;
   } result_type;

endpackage

`default_nettype wire

/* src/cia_exec.sv */
// register file, timers and interrupt logic, one transaction per step
`default_nettype none

module cia_exec (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire cia_pkg::item_type   item,
   output cia_pkg::result_type      result
);

   logic [7:0]  pra_ff, pra_in, prb_ff, prb_in;
   logic [7:0]  ddra_ff, ddra_in, ddrb_ff, ddrb_in;
   logic [15:0] ta_ff, ta_in, tb_ff, tb_in;
   logic [15:0] la_ff, la_in, lb_ff, lb_in;
   logic [7:0]  tod_ff [4];
   logic [7:0]  tod_in [4];
   logic [7:0]  sdr_ff, sdr_in;
   logic [7:0]  flags_ff, flags_in;
   logic [4:0]  mask_ff, mask_in;
   logic [7:0]  cra_ff, cra_in, crb_ff, crb_in;
   logic        flag_prev_ff, flag_prev_in;
   logic [7:0]  rd;

   always_comb begin
      logic ta_under;
      logic tb_en;
      logic tb_under;
      logic [15:0] new_latch;

      pra_in       = pra_ff;
      prb_in       = prb_ff;
      ddra_in      = ddra_ff;
      ddrb_in      = ddrb_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      la_in        = la_ff;
      lb_in        = lb_ff;
      tod_in       = tod_ff;
      sdr_in       = sdr_ff;
      flags_in     = flags_ff;
      mask_in      = mask_ff;
      cra_in       = cra_ff;
      crb_in       = crb_ff;
      flag_prev_in = flag_prev_ff;
      rd           = 8'd0;
      ta_under     = 1'b0;
      tb_en        = 1'b0;
      tb_under     = 1'b0;
      new_latch    = 16'd0;

      case (item.cmd)
         cia_pkg::CMD_TICK: begin
            if (cra_ff[cia_pkg::CR_START]) begin
               if (ta_ff == 16'd0) begin
                  ta_under = 1'b1;
                  ta_in    = la_ff;
                  if (cra_ff[cia_pkg::CR_ONESHOT]) cra_in[cia_pkg::CR_START] = 1'b0;
               end else begin
                  ta_in = ta_ff - 16'd1;
               end
            end
            // timer b counts either ticks or timer a underflows
            tb_en = crb_ff[cia_pkg::CR_START] &&
                    (crb_ff[cia_pkg::CR_CHAIN] ? ta_under : 1'b1);
            if (tb_en) begin
               if (tb_ff == 16'd0) begin
                  tb_under = 1'b1;
                  tb_in    = lb_ff;
                  if (crb_ff[cia_pkg::CR_ONESHOT]) crb_in[cia_pkg::CR_START] = 1'b0;
               end else begin
                  tb_in = tb_ff - 16'd1;
               end
            end
            flags_in[cia_pkg::ICR_TA] = flags_ff[cia_pkg::ICR_TA] | ta_under;
            flags_in[cia_pkg::ICR_TB] = flags_ff[cia_pkg::ICR_TB] | tb_under;
            if (ta_under || tb_under)
               flags_in[cia_pkg::ICR_SUMMARY] = |(flags_in[4:0] & mask_ff);
         end
         cia_pkg::CMD_READ: begin
            case (item.reg_addr)
               cia_pkg::REG_PRA:  rd = (pra_ff | ~ddra_ff) & item.port_a_pins;
               cia_pkg::REG_PRB:  rd = (prb_ff | ~ddrb_ff) & item.port_b_pins;
               cia_pkg::REG_DDRA: rd = ddra_ff;
               cia_pkg::REG_DDRB: rd = ddrb_ff;
               cia_pkg::REG_TALO: rd = ta_ff[7:0];
               cia_pkg::REG_TAHI: rd = ta_ff[15:8];
               cia_pkg::REG_TBLO: rd = tb_ff[7:0];
               cia_pkg::REG_TBHI: rd = tb_ff[15:8];
               cia_pkg::REG_TOD0, cia_pkg::REG_TOD1,
               cia_pkg::REG_TOD2, cia_pkg::REG_TOD3: rd = tod_ff[item.reg_addr[1:0]];
               cia_pkg::REG_SDR:  rd = sdr_ff;
               cia_pkg::REG_ICR: begin
                  // read clears all flags
                  rd       = flags_ff;
                  flags_in = 8'd0;
               end
               cia_pkg::REG_CRA:  rd = cra_ff;
               default:           rd = crb_ff;
            endcase
         end
         cia_pkg::CMD_WRITE: begin
            case (item.reg_addr)
               cia_pkg::REG_PRA:  pra_in  = item.write_data;
               cia_pkg::REG_PRB:  prb_in  = item.write_data;
               cia_pkg::REG_DDRA: ddra_in = item.write_data;
               cia_pkg::REG_DDRB: ddrb_in = item.write_data;
               cia_pkg::REG_TALO: la_in   = {la_ff[15:8], item.write_data};
               cia_pkg::REG_TAHI: begin
                  new_latch = {item.write_data, la_ff[7:0]};
                  la_in     = new_latch;
                  if (!cra_ff[cia_pkg::CR_START]) ta_in = new_latch;
               end
               cia_pkg::REG_TBLO: lb_in   = {lb_ff[15:8], item.write_data};
               cia_pkg::REG_TBHI: begin
                  new_latch = {item.write_data, lb_ff[7:0]};
                  lb_in     = new_latch;
                  if (!crb_ff[cia_pkg::CR_START]) tb_in = new_latch;
               end
               cia_pkg::REG_TOD0: tod_in[0] = {4'd0, item.write_data[3:0]};
               cia_pkg::REG_TOD1: tod_in[1] = item.write_data;
               cia_pkg::REG_TOD2: tod_in[2] = item.write_data;
               cia_pkg::REG_TOD3: tod_in[3] = item.write_data;
               cia_pkg::REG_SDR:  sdr_in    = item.write_data;
               cia_pkg::REG_ICR: begin
                  // set or clear mask bits, then refresh the summary bit
                  if (item.write_data[cia_pkg::ICR_SET])
                     mask_in = mask_ff | item.write_data[4:0];
                  else
                     mask_in = mask_ff & ~item.write_data[4:0];
                  flags_in[cia_pkg::ICR_SUMMARY] = |(flags_ff[4:0] & mask_in);
               end
               cia_pkg::REG_CRA: begin
                  cra_in                   = item.write_data;
                  cra_in[cia_pkg::CR_LOAD] = 1'b0;
                  if (item.write_data[cia_pkg::CR_LOAD]) ta_in = la_ff;
               end
               default: begin
                  crb_in                   = item.write_data;
                  crb_in[cia_pkg::CR_LOAD] = 1'b0;
                  if (item.write_data[cia_pkg::CR_LOAD]) tb_in = lb_ff;
               end
            endcase
         end
         default: begin
            // falling edge on the flag line
            if (flag_prev_ff && !item.flag_level) begin
               flags_in[cia_pkg::ICR_FLAG]    = 1'b1;
               flags_in[cia_pkg::ICR_SUMMARY] = |(flags_in[4:0] & mask_ff);
            end
            flag_prev_in = item.flag_level;
         end
      endcase
   end

   assign result.read_data  = rd;
   assign result.irq_line   = flags_in[cia_pkg::ICR_SUMMARY];
   assign result.port_a_out = pra_in | ~ddra_in;
   assign result.port_b_out = prb_in | ~ddrb_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pra_ff       <= 8'd0;
         prb_ff       <= 8'd0;
         ddra_ff      <= 8'd0;
         ddrb_ff      <= 8'd0;
         ta_ff        <= cia_pkg::TIMER_RESET;
         tb_ff        <= cia_pkg::TIMER_RESET;
         la_ff        <= cia_pkg::TIMER_RESET;
         lb_ff        <= cia_pkg::TIMER_RESET;
         tod_ff       <= '{default: 8'd0};
         sdr_ff       <= 8'd0;
         flags_ff     <= 8'd0;
         mask_ff      <= 5'd0;
         cra_ff       <= 8'd0;
         crb_ff       <= 8'd0;
         flag_prev_ff <= 1'b0;
      end else if (step) begin
         pra_ff       <= pra_in;
         prb_ff       <= prb_in;
         ddra_ff      <= ddra_in;
         ddrb_ff      <= ddrb_in;
         ta_ff        <= ta_in;
         tb_ff        <= tb_in;
         la_ff        <= la_in;
         lb_ff        <= lb_in;
         tod_ff       <= tod_in;
         sdr_ff       <= sdr_in;
         flags_ff     <= flags_in;
         mask_ff      <= mask_in;
         cra_ff       <= cra_in;
         crb_ff       <= crb_in;
         flag_prev_ff <= flag_prev_in;
      end
   end

endmodule

`default_nettype wire

/* src/cia_timer_port_interrupt_block_unit.sv */
// top level: input register, execute logic and result register
//
//   channel   dir   handshake               payload
//   req_      in    req_valid / req_ready   cmd, reg_addr, write_data, pins, flag_level
//   rsp_      out   rsp_valid / rsp_ready   read_data, irq_line, port_a_out, port_b_out
//
// each transaction passes from acceptance into the input register, then through the
// execute logic into the result register
// a new transaction is taken every cycle while results are not stalled; the state update
// of the execute stage is the only loop
// synchronous reset clears valid flags and execute state; timers, latches go to all ones
// a stalled result holds the input register, further requests wait in place
`default_nettype none

module cia_timer_port_interrupt_block_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_cmd,
   input  wire logic [3:0] req_reg_addr,
   input  wire logic [7:0] req_write_data,
   input  wire logic [7:0] req_port_a_pins,
   input  wire logic [7:0] req_port_b_pins,
   input  wire logic       req_flag_level,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_irq_line,
   output logic [7:0]      rsp_port_a_out,
   output logic [7:0]      rsp_port_b_out
);

   // input stage holding one transaction
   cia_pkg::item_type   item_ff, item_in;
   logic                in_valid_ff, in_valid_in;
   // result stage
   cia_pkg::result_type result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;
   cia_pkg::result_type exec_result;
   logic                advance;
   logic                req_fire;

   // execute when the result register is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      item_in.cmd         = req_cmd;
      item_in.reg_addr    = req_reg_addr;
      item_in.write_data  = req_write_data;
      item_in.port_a_pins = req_port_a_pins;
      item_in.port_b_pins = req_port_b_pins;
      item_in.flag_level  = req_flag_level;
   end

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign result_in    = exec_result;

   cia_exec u_exec (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .result (exec_result)
   );

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) item_ff <= item_in;
      if (advance) result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = result_ff.read_data;
   assign rsp_irq_line   = result_ff.irq_line;
   assign rsp_port_a_out = result_ff.port_a_out;
   assign rsp_port_b_out = result_ff.port_b_out;

`ifndef SYNTHESIS
   // an accepted request sits in the input register next cycle
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted request not held in input register");

   // an executed transaction always produces a result
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("executed transaction produced no result");

   // full pipeline with a stalled result must refuse new requests
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while pipeline full and stalled");
`endif

endmodule

`default_nettype wire

/* verif/cia_timer_port_interrupt_block_unit_tb.sv */
// testbench: timers, ports and interrupt flags checked against an in-bench predictor
`timescale 1ns / 100ps

module cia_timer_port_interrupt_block_unit_tb;

   localparam int NUM_RANDOM     = 550;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_OFF       = 40;    // long receiver stall, fills the pipeline
   localparam int DRAIN_AT       = 400;   // sender waits here until all results are back

   // one row of the directed table; want is only used where typed is set
   typedef struct {
      cia_pkg::item_type   stim;
      bit                  typed;
      cia_pkg::result_type want;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_cmd = cia_pkg::CMD_TICK;
   logic [3:0] req_reg_addr = cia_pkg::REG_PRA;
   logic [7:0] req_write_data = 8'h00;
   logic [7:0] req_port_a_pins = 8'h00;
   logic [7:0] req_port_b_pins = 8'h00;
   logic       req_flag_level = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_irq_line;
   logic [7:0] rsp_port_a_out;
   logic [7:0] rsp_port_b_out;

   // typed expectation travels alongside the payload of a directed row
   logic                row_typed = 1'b0;
   cia_pkg::result_type row_want = '0;

   row_type             directed_rows[$];
   cia_pkg::result_type pending_results[$];
   int                  mismatch_count = 0;
   int                  quiet_cycles = 0;

   // predicted adapter state
   logic [7:0]  pa_data, pb_data, pa_dir, pb_dir;
   logic [15:0] ta_count, tb_count, ta_latch, tb_latch;
   logic [7:0]  tod_regs [4];
   logic [7:0]  sdr, icr_flags, cra, crb;
   logic [4:0]  icr_mask;
   logic        flag_last;

   always #5 clock = ~clock;

   cia_timer_port_interrupt_block_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_reg_addr    (req_reg_addr),
      .req_write_data  (req_write_data),
      .req_port_a_pins (req_port_a_pins),
      .req_port_b_pins (req_port_b_pins),
      .req_flag_level  (req_flag_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_line    (rsp_irq_line),
      .rsp_port_a_out  (rsp_port_a_out),
      .rsp_port_b_out  (rsp_port_b_out)
   );

   // summary bit follows the masked flags, only when asked to
   function void update_summary();
      icr_flags[cia_pkg::ICR_SUMMARY] = |(icr_flags[4:0] & icr_mask);
   endfunction

   // one count of timer b, from a tick or from a timer a underflow
   function void count_timer_b();
      if (tb_count == 16'h0000) begin
         tb_count = tb_latch;
         icr_flags[cia_pkg::ICR_TB] = 1'b1;
         if (crb[cia_pkg::CR_ONESHOT]) crb[cia_pkg::CR_START] = 1'b0;
      end else begin
         tb_count = tb_count - 16'd1;
      end
   endfunction

   // next state and result of the adapter for one accepted transaction
   function cia_pkg::result_type step_adapter(cia_pkg::item_type it);
      cia_pkg::result_type r;
      logic [15:0] was;
      r.read_data = 8'h00;
      case (it.cmd)
         cia_pkg::CMD_TICK: begin
            if (cra[cia_pkg::CR_START]) begin
               if (ta_count == 16'h0000) begin
                  ta_count = ta_latch;
                  icr_flags[cia_pkg::ICR_TA] = 1'b1;
                  if (cra[cia_pkg::CR_ONESHOT]) cra[cia_pkg::CR_START] = 1'b0;
                  // chained timer b sees the underflow only while it runs
                  if (crb[cia_pkg::CR_CHAIN] && crb[cia_pkg::CR_START]) count_timer_b();
                  update_summary();
               end else begin
                  ta_count = ta_count - 16'd1;
               end
            end
            if (crb[cia_pkg::CR_START] && !crb[cia_pkg::CR_CHAIN]) begin
               was = tb_count;
               count_timer_b();
               if (was == 16'h0000) update_summary();
            end
         end
         cia_pkg::CMD_READ: begin
            case (it.reg_addr)
               cia_pkg::REG_PRA:  r.read_data = (pa_data | ~pa_dir) & it.port_a_pins;
               cia_pkg::REG_PRB:  r.read_data = (pb_data | ~pb_dir) & it.port_b_pins;
               cia_pkg::REG_DDRA: r.read_data = pa_dir;
               cia_pkg::REG_DDRB: r.read_data = pb_dir;
               cia_pkg::REG_TALO: r.read_data = ta_count[7:0];
               cia_pkg::REG_TAHI: r.read_data = ta_count[15:8];
               cia_pkg::REG_TBLO: r.read_data = tb_count[7:0];
               cia_pkg::REG_TBHI: r.read_data = tb_count[15:8];
               cia_pkg::REG_TOD0, cia_pkg::REG_TOD1,
               cia_pkg::REG_TOD2, cia_pkg::REG_TOD3:
                  r.read_data = tod_regs[it.reg_addr[1:0]];
               cia_pkg::REG_SDR:  r.read_data = sdr;
               cia_pkg::REG_ICR: begin
                  // read clears every flag, summary included
                  r.read_data = icr_flags;
                  icr_flags = 8'h00;
               end
               cia_pkg::REG_CRA:  r.read_data = cra;
               cia_pkg::REG_CRB:  r.read_data = crb;
            endcase
         end
         cia_pkg::CMD_WRITE: begin
            case (it.reg_addr)
               cia_pkg::REG_PRA:  pa_data = it.write_data;
               cia_pkg::REG_PRB:  pb_data = it.write_data;
               cia_pkg::REG_DDRA: pa_dir = it.write_data;
               cia_pkg::REG_DDRB: pb_dir = it.write_data;
               cia_pkg::REG_TALO: ta_latch[7:0] = it.write_data;
               cia_pkg::REG_TAHI: begin
                  ta_latch[15:8] = it.write_data;
                  if (!cra[cia_pkg::CR_START]) ta_count = ta_latch;
               end
               cia_pkg::REG_TBLO: tb_latch[7:0] = it.write_data;
               cia_pkg::REG_TBHI: begin
                  tb_latch[15:8] = it.write_data;
                  if (!crb[cia_pkg::CR_START]) tb_count = tb_latch;
               end
               cia_pkg::REG_TOD0: tod_regs[0] = {4'h0, it.write_data[3:0]};
               cia_pkg::REG_TOD1, cia_pkg::REG_TOD2, cia_pkg::REG_TOD3:
                  tod_regs[it.reg_addr[1:0]] = it.write_data;
               cia_pkg::REG_SDR:  sdr = it.write_data;
               cia_pkg::REG_ICR: begin
                  if (it.write_data[cia_pkg::ICR_SET])
                     icr_mask = icr_mask | it.write_data[4:0];
                  else
                     icr_mask = icr_mask & ~it.write_data[4:0];
                  update_summary();
               end
               cia_pkg::REG_CRA: begin
                  cra = it.write_data;
                  if (it.write_data[cia_pkg::CR_LOAD]) begin
                     ta_count = ta_latch;
                     cra[cia_pkg::CR_LOAD] = 1'b0;
                  end
               end
               cia_pkg::REG_CRB: begin
                  crb = it.write_data;
                  if (it.write_data[cia_pkg::CR_LOAD]) begin
                     tb_count = tb_latch;
                     crb[cia_pkg::CR_LOAD] = 1'b0;
                  end
               end
            endcase
         end
         cia_pkg::CMD_FLAG: begin
            // falling edge on the flag pin
            if (flag_last && !it.flag_level) begin
               icr_flags[cia_pkg::ICR_FLAG] = 1'b1;
               update_summary();
            end
            flag_last = it.flag_level;
         end
      endcase
      r.irq_line   = icr_flags[cia_pkg::ICR_SUMMARY];
      r.port_a_out = pa_data | ~pa_dir;
      r.port_b_out = pb_data | ~pb_dir;
      return r;
   endfunction

   function void add_row(logic [1:0] cmd, logic [3:0] addr, logic [7:0] data,
                         logic [7:0] pa, logic [7:0] pb, logic lvl,
                         bit typed, cia_pkg::result_type want);
      row_type row;
      row.stim  = {cmd, addr, data, pa, pb, lvl};
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // random transaction, biased toward short timer periods and running timers
   function cia_pkg::item_type random_request();
      cia_pkg::item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      it.cmd = (pick < 45) ? cia_pkg::CMD_TICK : (pick < 65) ? cia_pkg::CMD_READ :
               (pick < 90) ? cia_pkg::CMD_WRITE : cia_pkg::CMD_FLAG;
      it.reg_addr    = 4'($urandom_range(0, 15));
      it.write_data  = 8'($urandom);
      it.port_a_pins = 8'($urandom);
      it.port_b_pins = 8'($urandom);
      it.flag_level  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      case (it.reg_addr)
         cia_pkg::REG_TALO, cia_pkg::REG_TBLO:
            if (pick < 70) it.write_data = 8'($urandom_range(0, 7));
         cia_pkg::REG_TAHI, cia_pkg::REG_TBHI:
            if (pick < 75) it.write_data = 8'h00;
         cia_pkg::REG_CRA, cia_pkg::REG_CRB:
            if (pick < 75) it.write_data[cia_pkg::CR_START] = 1'b1;
         default: ;
      endcase
      return it;
   endfunction

   function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // scoreboard: check results in order, predict accepted requests, watch for hangs
   always @(posedge clock) begin : scoreboard
      cia_pkg::item_type   taken;
      cia_pkg::result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h %b %h %h", $time,
                        rsp_read_data, rsp_irq_line, rsp_port_a_out, rsp_port_b_out);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("irq_line", {7'd0, want.irq_line}, {7'd0, rsp_irq_line});
               check_field("port_a_out", want.port_a_out, rsp_port_a_out);
               check_field("port_b_out", want.port_b_out, rsp_port_b_out);
            end
         end
         if (req_valid && req_ready) begin
            taken.cmd         = req_cmd;
            taken.reg_addr    = req_reg_addr;
            taken.write_data  = req_write_data;
            taken.port_a_pins = req_port_a_pins;
            taken.port_b_pins = req_port_b_pins;
            taken.flag_level  = req_flag_level;
            // predictor always steps, a typed row only replaces the expected value
            want = step_adapter(taken);
            pending_results.push_back(row_typed ? row_want : want);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
               $display("** cia_timer_port_interrupt_block_unit: FAILED **");
               $finish;
            end
         end
      end
   end

   // result side: random stalls, one long hold-off, and a stretch with none
   initial begin : receiver
      int gap;
      int results_taken;
      results_taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (results_taken == 120) gap = HOLD_OFF;
         else if (results_taken >= 300 && results_taken < 400) gap = 0;
         else gap = $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_taken++;
      end
   end

   // request side: directed table first, then random traffic
   initial begin : sender
      cia_pkg::item_type   it;
      bit                  typed;
      cia_pkg::result_type want;
      int                  gap;
      int                  total;

      // predictor reset state
      pa_data = 8'h00; pb_data = 8'h00; pa_dir = 8'h00; pb_dir = 8'h00;
      ta_count = cia_pkg::TIMER_RESET; tb_count = cia_pkg::TIMER_RESET;
      ta_latch = cia_pkg::TIMER_RESET; tb_latch = cia_pkg::TIMER_RESET;
      for (int k = 0; k < 4; k++) tod_regs[k] = 8'h00;
      sdr = 8'h00; icr_flags = 8'h00; icr_mask = 5'h00;
      cra = 8'h00; crb = 8'h00; flag_last = 1'b0;

      // reset values, read straight off the register map
      add_row(cia_pkg::CMD_READ,  cia_pkg::REG_TALO, 8'h00, 8'hFF, 8'hFF, 1'b0,
              1'b1, {8'hFF, 1'b0, 8'hFF, 8'hFF});
      add_row(cia_pkg::CMD_READ,  cia_pkg::REG_ICR,  8'hFF, 8'h00, 8'h00, 1'b1,
              1'b1, {8'h00, 1'b0, 8'hFF, 8'hFF});
      add_row(cia_pkg::CMD_READ,  cia_pkg::REG_DDRA, 8'h00, 8'h00, 8'h00, 1'b0,
              1'b1, {8'h00, 1'b0, 8'hFF, 8'hFF});
      // port a all outputs, then data at both extremes
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_DDRA, 8'hFF, 8'h00, 8'h00, 1'b0,
              1'b1, {8'h00, 1'b0, 8'h00, 8'hFF});
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_PRA,  8'hFF, 8'hFF, 8'hFF, 1'b0,
              1'b1, {8'h00, 1'b0, 8'hFF, 8'hFF});
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_PRA,  8'h00, 8'h00, 8'h00, 1'b0,
              1'b1, {8'h00, 1'b0, 8'h00, 8'hFF});
      add_row(cia_pkg::CMD_READ,  cia_pkg::REG_PRA,  8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0, '0);
      // port b half in, half out, read through the pins
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_DDRB, 8'h0F, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_PRB,  8'hA5, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(cia_pkg::CMD_READ,  cia_pkg::REG_PRB,  8'h00, 8'h00, 8'h5A, 1'b0, 1'b0, '0);
      // timer a period one, timer b zero, chained
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_TALO, 8'h01, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_TAHI, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_TBLO, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_TBHI, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_ICR,  8'h9F, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      // timer b counts timer a underflows, force load on both
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_CRB,  8'h51, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      // timer a one-shot, stops after its first underflow
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_CRA,  8'h19, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(cia_pkg::CMD_TICK,  cia_pkg::REG_PRA,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(cia_pkg::CMD_TICK,  cia_pkg::REG_PRA,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(cia_pkg::CMD_TICK,  cia_pkg::REG_CRB,  8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, '0);
      add_row(cia_pkg::CMD_READ,  cia_pkg::REG_ICR,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      // flag pin high then low raises the flag interrupt
      add_row(cia_pkg::CMD_FLAG,  cia_pkg::REG_PRA,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '0);
      add_row(cia_pkg::CMD_FLAG,  cia_pkg::REG_PRA,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      // tenths register keeps only its low nibble
      add_row(cia_pkg::CMD_WRITE, cia_pkg::REG_TOD0, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(cia_pkg::CMD_READ,  cia_pkg::REG_TOD0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      total = directed_rows.size() + NUM_RANDOM;
      for (int n = 0; n < total; n++) begin
         if (n < directed_rows.size()) begin
            it    = directed_rows[n].stim;
            typed = directed_rows[n].typed;
            want  = directed_rows[n].want;
         end else begin
            it    = random_request();
            typed = 1'b0;
            want  = '0;
         end
         if (n == DRAIN_AT) begin
            // pause until every outstanding result has come back
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_results.size() != 0);
            gap = 0;
         end else if (n >= 200 && n < 300) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 3);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid       <= 1'b1;
         req_cmd         <= it.cmd;
         req_reg_addr    <= it.reg_addr;
         req_write_data  <= it.write_data;
         req_port_a_pins <= it.port_a_pins;
         req_port_b_pins <= it.port_b_pins;
         req_flag_level  <= it.flag_level;
         row_typed       <= typed;
         row_want        <= want;
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;

      // wait out the results still in flight, then let the pipeline drain
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** cia_timer_port_interrupt_block_unit: PASSED **");
      end else begin
         $display("** cia_timer_port_interrupt_block_unit: FAILED **");
      end
      $finish;
   end

endmodule
